// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes for the scene text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Token kind codes
    localparam logic [2:0] KIND_SKIP   = 3'd0;
    localparam logic [2:0] KIND_QUOTE  = 3'd1;
    localparam logic [2:0] KIND_OPEN   = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;
    localparam logic [2:0] KIND_WORD   = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;

    localparam int LINE_W = 32;

    typedef struct packed {
        logic       action;
        logic [7:0] char_in;
        logic       any_string;
    } stt_in_t;

    typedef struct packed {
        logic [2:0]        token_kind;
        logic              starts_token;
        logic [7:0]        char_out;
        logic              bad_char;
        logic [LINE_W-1:0] line_number;
    } stt_out_t;

endpackage

`default_nettype wire

// ===== design/scene_text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// scene_text_tokenizer_top
// Streaming lexer for scene description text, one labeled byte per input.
// ----------------------------------------------------------------------------
// Every input transaction (a text byte or an end-of-input mark) yields exactly
// one output transaction carrying the token kind, a token-start flag, the byte
// itself, an invalid-byte flag and the running newline count. The block takes
// one transaction per cycle when the output side is not stalling. An accepted
// transaction is loaded into the input register and, when it advances, into the
// result register, where the output transaction becomes valid. The
// lexer mode and line counter advance when an item moves from the input
// register into the result register, so each byte sees the mode left by the
// byte before it. A stalled result does not block the input register from
// being filled, so the upstream stall rises only when both registers are full
// and the downstream side is stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module scene_text_tokenizer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              text_valid,
    output      logic              text_stall,
    input  wire stt_pkg::stt_in_t  text_item,
    output      logic              token_valid,
    input  wire logic              token_stall,
    output      stt_pkg::stt_out_t token_item
);
    import stt_pkg::*;

    // Input register
    logic     text_valid_reg, text_valid_next;
    stt_in_t  text_reg;

    // Result register
    logic     token_valid_reg, token_valid_next;
    stt_out_t token_reg;

    logic     text_take;  // input transaction accepted
    logic     advance;    // input register moves into result register
    stt_out_t result;

    assign advance    = text_valid_reg && (!token_valid_reg || !token_stall);
    assign text_stall = text_valid_reg && !advance;
    assign text_take  = text_valid && !text_stall;

    stt_lex_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (text_reg),
        .result (result)
    );

    always_comb
    begin
        text_valid_next = text_valid_reg;
        if (text_take)
        begin
            text_valid_next = 1'b1;
        end
        else if (advance)
        begin
            text_valid_next = 1'b0;
        end

        token_valid_next = token_valid_reg;
        if (advance)
        begin
            token_valid_next = 1'b1;
        end
        else if (!token_stall)
        begin
            token_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid_reg  <= 1'b0;
            token_valid_reg <= 1'b0;
        end
        else
        begin
            text_valid_reg  <= text_valid_next;
            token_valid_reg <= token_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            text_reg <= text_item;
        end
        if (advance)
        begin
            token_reg <= result;
        end
    end

    assign token_valid = token_valid_reg;
    assign token_item  = token_reg;

endmodule

`default_nettype wire

// ===== design/stt_lex_core.sv =====
// ----------------------------------------------------------------------------
// stt_lex_core
// Lexer mode and line counter; labels one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_lex_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire stt_pkg::stt_in_t  item,
    output stt_pkg::stt_out_t      result
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_WORD    = 3'd3,
        MODE_ANY     = 3'd4
    } mode_t;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_E     = 8'h65;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    mode_t             mode_reg, mode_next;
    logic [LINE_W-1:0] count_reg, count_next;

    logic [7:0] c;
    logic       handled;
    logic       num_char;

    always_comb
    begin
        c          = item.char_in;
        num_char   = (c == CH_MINUS) || (c == CH_DOT) || (c == CH_E) || is_digit(c);
        handled    = 1'b0;
        mode_next  = mode_reg;
        count_next = count_reg;

        result.token_kind   = KIND_SKIP;
        result.starts_token = 1'b0;
        result.char_out     = c;
        result.bad_char     = 1'b0;

        if (item.action == ACT_END)
        begin
            mode_next           = MODE_IDLE;
            result.token_kind   = KIND_END;
            result.starts_token = 1'b1;
            result.char_out     = 8'h00;
        end
        else
        begin
            if (c == CH_NL && count_reg != {LINE_W{1'b1}})
            begin
                count_next = count_reg + LINE_W'(1);
            end

            // Continue an open token or comment
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (c == CH_NL)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    handled = 1'b1;
                end
                MODE_NUMBER:
                begin
                    if (num_char)
                    begin
                        result.token_kind = KIND_NUMBER;
                        handled           = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (c != CH_QUOTE && !is_space(c))
                    begin
                        result.token_kind = KIND_WORD;
                        handled           = 1'b1;
                    end
                end
                MODE_ANY:
                begin
                    if (c != CH_QUOTE)
                    begin
                        result.token_kind = KIND_WORD;
                        handled           = 1'b1;
                    end
                end
                default:
                begin
                    handled = 1'b0;
                end
            endcase

            // Token start (also the byte that closed a token)
            if (!handled)
            begin
                mode_next = MODE_IDLE;
                priority if (c == CH_HASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (is_space(c))
                begin
                    result.token_kind = KIND_SKIP;
                end
                else if (item.any_string && c != CH_QUOTE)
                begin
                    result.token_kind   = KIND_WORD;
                    result.starts_token = 1'b1;
                    mode_next           = MODE_ANY;
                end
                else if (c == CH_QUOTE)
                begin
                    result.token_kind   = KIND_QUOTE;
                    result.starts_token = 1'b1;
                end
                else if (c == CH_OPEN)
                begin
                    result.token_kind   = KIND_OPEN;
                    result.starts_token = 1'b1;
                end
                else if (c == CH_CLOSE)
                begin
                    result.token_kind   = KIND_CLOSE;
                    result.starts_token = 1'b1;
                end
                else if (c == CH_MINUS || c == CH_DOT || is_digit(c))
                begin
                    result.token_kind   = KIND_NUMBER;
                    result.starts_token = 1'b1;
                    mode_next           = MODE_NUMBER;
                end
                else if (is_alpha(c))
                begin
                    result.token_kind   = KIND_WORD;
                    result.starts_token = 1'b1;
                    mode_next           = MODE_WORD;
                end
                else
                begin
                    result.bad_char = 1'b1;
                end
            end
        end

        result.line_number = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/stt_checker.sv =====
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks for the scene text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              token_valid,
    input wire logic              token_stall,
    input wire stt_pkg::stt_out_t token_item
);
    import stt_pkg::*;

    // Nothing comes out while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !token_valid)
        else $error("token_valid high during reset");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_item))
        else $error("stalled token transaction changed");

    // End mark is a token start with a zero byte and no error
    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.token_kind == KIND_END
        |-> token_item.starts_token && token_item.char_out == 8'h00
            && !token_item.bad_char)
        else $error("malformed end transaction");

    // An invalid byte is skipped and starts nothing
    a_bad_skip: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.bad_char
        |-> token_item.token_kind == KIND_SKIP && !token_item.starts_token)
        else $error("bad byte labeled as token");

    // A token start never carries the skip kind
    a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_item.starts_token
        |-> token_item.token_kind != KIND_SKIP)
        else $error("token start labeled skip");

endmodule

bind scene_text_tokenizer_top stt_checker u_stt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
);

`default_nettype wire
